// File: rtl/seo_pkg.sv
package seo_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int DEPTH_BITS = 24;

	localparam int MIN_SIZE   = 3;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int CH_W       = 8;
	localparam int ST_W       = 8;
	localparam int SIZE_W     = 11;
	localparam int COLOR_W    = 32;
	localparam int NT_W       = 10;
	localparam int DT_W       = 24;
	localparam int KIND_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int WCMP_W = (SIZE_W > COL_W + 1) ? SIZE_W : COL_W + 1;
	localparam int HCMP_W = (SIZE_W > ROW_W + 1) ? SIZE_W : ROW_W + 1;

	localparam int NG_W   = CH_W + 3;
	localparam int NM_W   = CH_W + 2;
	localparam int DG_W   = DEPTH_BITS + 3;
	localparam int DM_W   = DEPTH_BITS + 2;
	localparam int GCMP_W = (DM_W > DT_W) ? DM_W : DT_W;
	localparam int DCMP_W = 2 * DT_W + 1;
	localparam int NCMP_W = ((NM_W > NT_W) ? 2 * NM_W : 2 * NT_W) + 1;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STENCIL_SKIP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER_COLOR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTER_COLOR  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_THR   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_THR    = 3'd6;

	typedef enum logic [KIND_W-1:0] {
		EDGE_NONE  = 2'd0,
		EDGE_INNER = 2'd1,
		EDGE_OUTER = 2'd2
	} edge_kind_t;

	typedef struct packed {
		logic [DEPTH_BITS-1:0] depth;
		logic [ST_W-1:0]       stencil;
		logic [CH_W-1:0]       b;
		logic [CH_W-1:0]       g;
		logic [CH_W-1:0]       r;
	} pix_t;

	typedef struct packed {
		logic             valid;
		logic             emit;
		logic             last;
		logic [COL_W-1:0] x;
		logic [ROW_W-1:0] y;
	} meta_t;

	typedef struct packed {
		logic                       big;
		logic                       keep;
		logic [DT_W-1:0]            da;
		logic [DT_W-1:0]            db;
		logic [2:0][NM_W-1:0]       nx;
		logic [2:0][NM_W-1:0]       ny;
	} grad_t;

endpackage

// File: rtl/seo_line_store.sv
module seo_line_store (
	input  logic                   clk,
	input  logic                   en,
	input  logic                   bank,
	input  logic [seo_pkg::COL_W-1:0] addr,
	input  seo_pkg::pix_t          wr_data,
	output seo_pkg::pix_t          above2,
	output seo_pkg::pix_t          above1
);
	import seo_pkg::*;

	pix_t bank0_mem [MAX_WIDTH];
	pix_t bank1_mem [MAX_WIDTH];
	pix_t rd0_q;
	pix_t rd1_q;
	logic bank_q;

	always_ff @(posedge clk) begin
		if (en) begin
			rd0_q  <= bank0_mem[addr];
			rd1_q  <= bank1_mem[addr];
			bank_q <= bank;
			if (!bank) begin
				bank0_mem[addr] <= wr_data;
			end else begin
				bank1_mem[addr] <= wr_data;
			end
		end
	end

	assign above2 = bank_q ? rd1_q : rd0_q;
	assign above1 = bank_q ? rd0_q : rd1_q;

endmodule

// File: rtl/seo_window.sv
module seo_window (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        shift,
	input  seo_pkg::pix_t               above2,
	input  seo_pkg::pix_t               above1,
	input  seo_pkg::pix_t               px,
	input  logic [seo_pkg::ST_W-1:0]    stencil_skip,
	input  logic [seo_pkg::DT_W-1:0]    depth_thr,
	output seo_pkg::grad_t              grad_s2
);
	import seo_pkg::*;

	pix_t win_q [3][3];

	logic [2:0][8:0][CH_W-1:0]   ch_v;
	logic [8:0][DEPTH_BITS-1:0]  dep_v;
	logic [2:0][NM_W-1:0]        nx_m;
	logic [2:0][NM_W-1:0]        ny_m;
	logic [GCMP_W-1:0]           da_w;
	logic [GCMP_W-1:0]           db_w;
	logic [GCMP_W-1:0]           thr_w;

	function automatic logic signed [NG_W-1:0] sobel_n(input logic [8:0][CH_W-1:0] v,
		input logic dir_y);
		logic signed [NG_W-1:0] p [9];
		for (int k = 0; k < 9; k++) begin
			p[k] = signed'(NG_W'(v[k]));
		end
		if (!dir_y) begin
			return (p[2] - p[0]) + ((p[5] - p[3]) <<< 1) + (p[8] - p[6]);
		end
		return (p[6] + (p[7] <<< 1) + p[8]) - (p[0] + (p[1] <<< 1) + p[2]);
	endfunction

	function automatic logic signed [DG_W-1:0] sobel_d(input logic [8:0][DEPTH_BITS-1:0] v,
		input logic dir_y);
		logic signed [DG_W-1:0] p [9];
		for (int k = 0; k < 9; k++) begin
			p[k] = signed'(DG_W'(v[k]));
		end
		if (!dir_y) begin
			return (p[2] - p[0]) + ((p[5] - p[3]) <<< 1) + (p[8] - p[6]);
		end
		return (p[6] + (p[7] <<< 1) + p[8]) - (p[0] + (p[1] <<< 1) + p[2]);
	endfunction

	function automatic logic [NM_W-1:0] mag_n(input logic signed [NG_W-1:0] g);
		logic signed [NG_W-1:0] a;
		a = g[NG_W-1] ? -g : g;
		return NM_W'(a);
	endfunction

	function automatic logic [DM_W-1:0] mag_d(input logic signed [DG_W-1:0] g);
		logic signed [DG_W-1:0] a;
		a = g[DG_W-1] ? -g : g;
		return DM_W'(a);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 3; j++) begin
				for (int i = 0; i < 3; i++) begin
					win_q[j][i] <= '0;
				end
			end
		end else if (shift) begin
			for (int j = 0; j < 3; j++) begin
				win_q[j][0] <= win_q[j][1];
				win_q[j][1] <= win_q[j][2];
			end
			win_q[0][2] <= above2;
			win_q[1][2] <= above1;
			win_q[2][2] <= px;
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			for (int i = 0; i < 3; i++) begin
				ch_v[0][j*3+i] = win_q[j][i].r;
				ch_v[1][j*3+i] = win_q[j][i].g;
				ch_v[2][j*3+i] = win_q[j][i].b;
				dep_v[j*3+i]   = win_q[j][i].depth;
			end
		end
		for (int c = 0; c < 3; c++) begin
			nx_m[c] = mag_n(sobel_n(ch_v[c], 1'b0));
			ny_m[c] = mag_n(sobel_n(ch_v[c], 1'b1));
		end
		da_w  = GCMP_W'(mag_d(sobel_d(dep_v, 1'b0)));
		db_w  = GCMP_W'(mag_d(sobel_d(dep_v, 1'b1)));
		thr_w = GCMP_W'(depth_thr);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			grad_s2.big  <= (da_w > thr_w) || (db_w > thr_w);
			grad_s2.keep <= win_q[1][1].stencil != stencil_skip;
			grad_s2.da   <= DT_W'(da_w);
			grad_s2.db   <= DT_W'(db_w);
			grad_s2.nx   <= nx_m;
			grad_s2.ny   <= ny_m;
		end
	end

endmodule

// File: rtl/seo_classify.sv
module seo_classify (
	input  logic                     clk,
	input  logic                     adv,
	input  seo_pkg::grad_t           grad_s2,
	input  logic [seo_pkg::NT_W-1:0] normal_thr,
	input  logic [seo_pkg::DT_W-1:0] depth_thr,
	output seo_pkg::edge_kind_t      kind
);
	import seo_pkg::*;

	logic                        big_s3;
	logic                        keep_s3;
	logic [2*DT_W-1:0]           da2_s3;
	logic [2*DT_W-1:0]           db2_s3;
	logic [2*DT_W-1:0]           dt2_s3;
	logic [2:0][2*NM_W-1:0]      nx2_s3;
	logic [2:0][2*NM_W-1:0]      ny2_s3;
	logic [2*NT_W-1:0]           tn2_s3;
	logic                        outer;
	logic                        inner;

	always_ff @(posedge clk) begin
		if (adv) begin
			big_s3  <= grad_s2.big;
			keep_s3 <= grad_s2.keep;
			da2_s3  <= (2*DT_W)'(grad_s2.da) * (2*DT_W)'(grad_s2.da);
			db2_s3  <= (2*DT_W)'(grad_s2.db) * (2*DT_W)'(grad_s2.db);
			dt2_s3  <= (2*DT_W)'(depth_thr) * (2*DT_W)'(depth_thr);
			tn2_s3  <= (2*NT_W)'(normal_thr) * (2*NT_W)'(normal_thr);
			for (int c = 0; c < 3; c++) begin
				nx2_s3[c] <= (2*NM_W)'(grad_s2.nx[c]) * (2*NM_W)'(grad_s2.nx[c]);
				ny2_s3[c] <= (2*NM_W)'(grad_s2.ny[c]) * (2*NM_W)'(grad_s2.ny[c]);
			end
		end
	end

	always_comb begin
		outer = big_s3 ||
			((DCMP_W'(da2_s3) + DCMP_W'(db2_s3)) > DCMP_W'(dt2_s3));
		inner = 1'b0;
		for (int c = 0; c < 3; c++) begin
			if ((NCMP_W'(nx2_s3[c]) + NCMP_W'(ny2_s3[c])) >= NCMP_W'(tn2_s3)) begin
				inner = 1'b1;
			end
		end
		if (outer) begin
			kind = EDGE_OUTER;
		end else if (inner && keep_s3) begin
			kind = EDGE_INNER;
		end else begin
			kind = EDGE_NONE;
		end
	end

endmodule

// File: rtl/sobel_edge_outline.sv
// Streaming 3x3 Sobel edge classifier for a raster-order pixel stream.
// Throughput: one pixel per clock unless the output stalls; both line-store banks
// are read at the same column once per pixel; the row's parity picks the bank written.
// Pixels pass the input, window, gradient, square and output registers; reset clears
// the counters, window, stage metadata and output valid, sets registers to defaults,
// and does not clear the line store, as its first two rows give no result.
module sobel_edge_outline (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [seo_pkg::CH_W-1:0]          normal_r,
	input  logic [seo_pkg::CH_W-1:0]          normal_g,
	input  logic [seo_pkg::CH_W-1:0]          normal_b,
	input  logic [seo_pkg::DEPTH_BITS-1:0]    depth,
	input  logic [seo_pkg::ST_W-1:0]          stencil,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [seo_pkg::COL_W-1:0]         pixel_x,
	output logic [seo_pkg::ROW_W-1:0]         pixel_y,
	output logic [seo_pkg::KIND_W-1:0]        edge_kind,
	output logic [seo_pkg::COLOR_W-1:0]       write_color,
	output logic                              frame_last,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [seo_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [seo_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import seo_pkg::*;

	logic [SIZE_W-1:0]     width_q;
	logic [SIZE_W-1:0]     height_q;
	logic [ST_W-1:0]       skip_q;
	logic [COLOR_W-1:0]    inner_color_q;
	logic [COLOR_W-1:0]    outer_color_q;
	logic [NT_W-1:0]       normal_thr_q;
	logic [DT_W-1:0]       depth_thr_q;

	logic [COL_W-1:0]      col_q;
	logic [ROW_W-1:0]      row_q;

	logic [WCMP_W-1:0]     w_eff;
	logic [HCMP_W-1:0]     h_eff;
	logic [WCMP_W-1:0]     col_cur;
	logic [WCMP_W-1:0]     col_nx;
	logic [HCMP_W-1:0]     row_pre;
	logic [HCMP_W-1:0]     row_cur;
	logic [HCMP_W-1:0]     row_nx;
	logic                  wrap_c;

	logic                  adv;
	logic                  accept;
	pix_t                  px;
	pix_t                  px_s1;
	pix_t                  above2;
	pix_t                  above1;
	meta_t                 meta_s1;
	meta_t                 meta_s2;
	meta_t                 meta_s3;
	meta_t                 meta_s4;
	grad_t                 grad_s2;
	edge_kind_t            kind;

	logic                  out_valid_q;
	logic [COL_W-1:0]      pixel_x_q;
	logic [ROW_W-1:0]      pixel_y_q;
	logic [KIND_W-1:0]     edge_kind_q;
	logic [COLOR_W-1:0]    write_color_q;
	logic                  frame_last_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q       <= SIZE_W'(640);
			height_q      <= SIZE_W'(480);
			skip_q        <= '0;
			inner_color_q <= '0;
			outer_color_q <= '0;
			normal_thr_q  <= NT_W'(245);
			depth_thr_q   <= DT_W'(25600);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:  width_q       <= cfg_data[SIZE_W-1:0];
				CFG_FRAME_HEIGHT: height_q      <= cfg_data[SIZE_W-1:0];
				CFG_STENCIL_SKIP: skip_q        <= cfg_data[ST_W-1:0];
				CFG_INNER_COLOR:  inner_color_q <= cfg_data[COLOR_W-1:0];
				CFG_OUTER_COLOR:  outer_color_q <= cfg_data[COLOR_W-1:0];
				CFG_NORMAL_THR:   normal_thr_q  <= cfg_data[NT_W-1:0];
				CFG_DEPTH_THR:    depth_thr_q   <= cfg_data[DT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (WCMP_W'(width_q) < WCMP_W'(MIN_SIZE)) begin
			w_eff = WCMP_W'(MIN_SIZE);
		end else if (WCMP_W'(width_q) > WCMP_W'(MAX_WIDTH)) begin
			w_eff = WCMP_W'(MAX_WIDTH);
		end else begin
			w_eff = WCMP_W'(width_q);
		end
		if (HCMP_W'(height_q) < HCMP_W'(MIN_SIZE)) begin
			h_eff = HCMP_W'(MIN_SIZE);
		end else if (HCMP_W'(height_q) > HCMP_W'(MAX_HEIGHT)) begin
			h_eff = HCMP_W'(MAX_HEIGHT);
		end else begin
			h_eff = HCMP_W'(height_q);
		end

		// A size change between frames can leave the counters outside the frame.
		wrap_c  = WCMP_W'(col_q) >= w_eff;
		col_cur = wrap_c ? '0 : WCMP_W'(col_q);
		row_pre = HCMP_W'(row_q) + HCMP_W'(wrap_c);
		row_cur = (row_pre >= h_eff) ? '0 : row_pre;
		col_nx  = col_cur + WCMP_W'(1);
		row_nx  = row_cur + HCMP_W'(1);
	end

	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;
	assign accept   = in_valid && adv;

	assign px.r       = normal_r;
	assign px.g       = normal_g;
	assign px.b       = normal_b;
	assign px.stencil = stencil;
	assign px.depth   = depth;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_nx >= w_eff) begin
				col_q <= '0;
				row_q <= (row_nx >= h_eff) ? '0 : ROW_W'(row_nx);
			end else begin
				col_q <= COL_W'(col_nx);
				row_q <= ROW_W'(row_cur);
			end
		end
	end

	seo_line_store u_line_store (
		.clk     (clk),
		.en      (accept),
		.bank    (row_cur[0]),
		.addr    (COL_W'(col_cur)),
		.wr_data (px),
		.above2  (above2),
		.above1  (above1)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1 <= px;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
			meta_s2 <= '0;
			meta_s3 <= '0;
			meta_s4 <= '0;
		end else if (adv) begin
			meta_s1.valid <= in_valid;
			meta_s1.emit  <= in_valid && (col_cur >= WCMP_W'(2)) && (row_cur >= HCMP_W'(2));
			meta_s1.last  <= (col_cur == w_eff - WCMP_W'(1)) &&
				(row_cur == h_eff - HCMP_W'(1));
			meta_s1.x     <= COL_W'(col_cur - WCMP_W'(1));
			meta_s1.y     <= ROW_W'(row_cur - HCMP_W'(1));
			meta_s2       <= meta_s1;
			meta_s3       <= meta_s2;
			meta_s4       <= meta_s3;
		end
	end

	seo_window u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.shift        (adv && meta_s1.valid),
		.above2       (above2),
		.above1       (above1),
		.px           (px_s1),
		.stencil_skip (skip_q),
		.depth_thr    (depth_thr_q),
		.grad_s2      (grad_s2)
	);

	seo_classify u_classify (
		.clk        (clk),
		.adv        (adv),
		.grad_s2    (grad_s2),
		.normal_thr (normal_thr_q),
		.depth_thr  (depth_thr_q),
		.kind       (kind)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= meta_s4.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pixel_x_q    <= meta_s4.x;
			pixel_y_q    <= meta_s4.y;
			frame_last_q <= meta_s4.last;
			edge_kind_q  <= kind;
			case (kind)
				EDGE_OUTER: write_color_q <= outer_color_q;
				EDGE_INNER: write_color_q <= inner_color_q;
				default:    write_color_q <= '0;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign edge_kind   = edge_kind_q;
	assign write_color = write_color_q;
	assign frame_last  = frame_last_q;

endmodule

// File: verif/tb_sobel_edge_outline.sv
module tb_sobel_edge_outline;
	timeunit 1ns;
	timeprecision 1ps;

	import seo_pkg::*;

	localparam int DRAIN_CYCLES = 8;

	typedef enum int {
		PLANE_R,
		PLANE_G,
		PLANE_B,
		PLANE_DEPTH
	} plane_t;

	typedef struct packed {
		logic [COL_W-1:0] x;
		logic [ROW_W-1:0] y;
		edge_kind_t       kind;
		logic [COLOR_W-1:0] color;
		logic             last;
	} outline_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [CH_W-1:0]       normal_r = '0;
	logic [CH_W-1:0]       normal_g = '0;
	logic [CH_W-1:0]       normal_b = '0;
	logic [DEPTH_BITS-1:0] depth = '0;
	logic [ST_W-1:0]       stencil = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [COL_W-1:0]      pixel_x;
	logic [ROW_W-1:0]      pixel_y;
	logic [KIND_W-1:0]     edge_kind;
	logic [COLOR_W-1:0]    write_color;
	logic                  frame_last;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [SIZE_W-1:0]  frame_w_reg = 11'd640;
	logic [SIZE_W-1:0]  frame_h_reg = 11'd480;
	logic [ST_W-1:0]    skip_reg = 8'd0;
	logic [COLOR_W-1:0] inner_color_reg = '0;
	logic [COLOR_W-1:0] outer_color_reg = '0;
	logic [NT_W-1:0]    normal_thr_reg = 10'd245;
	logic [DT_W-1:0]    depth_thr_reg = 24'd25600;

	pix_t line_mem [2][MAX_WIDTH];
	pix_t win [3][3];
	int   col_pos = 0;
	int   row_pos = 0;

	pix_t     pixel_queue[$];
	outline_t outline_expect[$];
	pix_t     in_flight;
	int       pixels_sent = 0;
	int       pixels_taken = 0;
	int       mismatch_count = 0;
	int       sender_gap_pct = 0;
	int       receiver_stall_pct = 0;

	pix_t tone = '0;
	int   chan_spread = 0;
	int   depth_spread = 0;

	sobel_edge_outline DUT (.*);

	always #10 clk = ~clk;

	function automatic int fit_size(logic [SIZE_W-1:0] v, int hi);
		if (v < MIN_SIZE)
			return MIN_SIZE;
		return (v > hi) ? hi : int'(v);
	endfunction

	function automatic longint plane_val(pix_t p, plane_t f);
		case (f)
			PLANE_R: return longint'(p.r);
			PLANE_G: return longint'(p.g);
			PLANE_B: return longint'(p.b);
			default: return longint'(p.depth);
		endcase
	endfunction

	function automatic longint gradient_sq(plane_t f);
		longint v [3][3];
		longint gx, gy;
		int j, i;
		for (j = 0; j < 3; j++)
			for (i = 0; i < 3; i++)
				v[j][i] = plane_val(win[j][i], f);
		gx = (v[0][2] + 2 * v[1][2] + v[2][2]) - (v[0][0] + 2 * v[1][0] + v[2][0]);
		gy = (v[2][0] + 2 * v[2][1] + v[2][2]) - (v[0][0] + 2 * v[0][1] + v[0][2]);
		return gx * gx + gy * gy;
	endfunction

	function automatic void classify_pixel(pix_t px);
		int w, h, col, row, par, j;
		pix_t above1, above2;
		outline_t res;
		longint nt_sq, dt_sq;
		logic outer, inner;
		w = fit_size(frame_w_reg, MAX_WIDTH);
		h = fit_size(frame_h_reg, MAX_HEIGHT);
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h)
			row_pos = 0;
		col = col_pos;
		row = row_pos;
		par = row & 1;
		above2 = line_mem[par][col];
		above1 = line_mem[par ^ 1][col];
		line_mem[par][col] = px;
		for (j = 0; j < 3; j++) begin
			win[j][0] = win[j][1];
			win[j][1] = win[j][2];
		end
		win[0][2] = above2;
		win[1][2] = above1;
		win[2][2] = px;
		if (col >= 2 && row >= 2) begin
			dt_sq = longint'(depth_thr_reg) * longint'(depth_thr_reg);
			nt_sq = longint'(normal_thr_reg) * longint'(normal_thr_reg);
			outer = gradient_sq(PLANE_DEPTH) > dt_sq;
			inner = gradient_sq(PLANE_R) >= nt_sq || gradient_sq(PLANE_G) >= nt_sq
				|| gradient_sq(PLANE_B) >= nt_sq;
			if (win[1][1].stencil == skip_reg)
				inner = 1'b0;
			res.x = COL_W'(col - 1);
			res.y = ROW_W'(row - 1);
			res.last = (col == w - 1 && row == h - 1);
			if (outer) begin
				res.kind = EDGE_OUTER;
				res.color = outer_color_reg;
			end else if (inner) begin
				res.kind = EDGE_INNER;
				res.color = inner_color_reg;
			end else begin
				res.kind = EDGE_NONE;
				res.color = '0;
			end
			outline_expect.push_back(res);
		end
		col_pos = col + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = row + 1;
			if (row_pos >= h)
				row_pos = 0;
		end
	endfunction

	function automatic pix_t rand_pixel();
		pix_t p;
		if ($urandom_range(15) == 0)
			tone = 56'({$urandom, $urandom});
		if ($urandom_range(7) == 0) begin
			p = 56'({$urandom, $urandom});
			return p;
		end
		p.r = CH_W'(tone.r + $urandom_range(chan_spread));
		p.g = CH_W'(tone.g + $urandom_range(chan_spread));
		p.b = CH_W'(tone.b + $urandom_range(chan_spread));
		p.depth = DEPTH_BITS'(tone.depth + $urandom_range(depth_spread));
		p.stencil = ($urandom_range(9) < 3) ? skip_reg : 8'($urandom);
		return p;
	endfunction

	task automatic send_pixel(pix_t p);
		pixel_queue.push_back(p);
		pixels_sent++;
	endtask

	task automatic settle();
		while (pixels_taken != pixels_sent || outline_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_FRAME_WIDTH:  frame_w_reg = data[SIZE_W-1:0];
			CFG_FRAME_HEIGHT: frame_h_reg = data[SIZE_W-1:0];
			CFG_STENCIL_SKIP: skip_reg = data[ST_W-1:0];
			CFG_INNER_COLOR:  inner_color_reg = data;
			CFG_OUTER_COLOR:  outer_color_reg = data;
			CFG_NORMAL_THR:   normal_thr_reg = data[NT_W-1:0];
			CFG_DEPTH_THR:    depth_thr_reg = data[DT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [SIZE_W-1:0] fw, logic [SIZE_W-1:0] fh,
		logic [ST_W-1:0] skip, logic [COLOR_W-1:0] in_col, logic [COLOR_W-1:0] out_col,
		logic [NT_W-1:0] nthr, logic [DT_W-1:0] dthr);
		write_reg(CFG_FRAME_WIDTH, 32'(fw));
		write_reg(CFG_FRAME_HEIGHT, 32'(fh));
		write_reg(CFG_STENCIL_SKIP, 32'(skip));
		write_reg(CFG_INNER_COLOR, in_col);
		write_reg(CFG_OUTER_COLOR, out_col);
		write_reg(CFG_NORMAL_THR, 32'(nthr));
		write_reg(CFG_DEPTH_THR, 32'(dthr));
	endtask

	// A request held under stall keeps its payload until it is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				classify_pixel(in_flight);
				pixels_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (pixel_queue.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
					in_flight = pixel_queue.pop_front();
					in_valid <= 1'b1;
					normal_r <= in_flight.r;
					normal_g <= in_flight.g;
					normal_b <= in_flight.b;
					depth <= in_flight.depth;
					stencil <= in_flight.stencil;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		outline_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (outline_expect.size() == 0) begin
					$error("unexpected result at pixel_x %0d, pixel_y %0d", pixel_x, pixel_y);
					mismatch_count++;
				end else begin
					want = outline_expect.pop_front();
					if (pixel_x !== want.x) begin
						$error("pixel_x: expected %0d, got %0d", want.x, pixel_x);
						mismatch_count++;
					end
					if (pixel_y !== want.y) begin
						$error("pixel_y: expected %0d, got %0d", want.y, pixel_y);
						mismatch_count++;
					end
					if (edge_kind !== want.kind) begin
						$error("edge_kind: expected %0d, got %0d", want.kind, edge_kind);
						mismatch_count++;
					end
					if (write_color !== want.color) begin
						$error("write_color: expected %h, got %h", want.color, write_color);
						mismatch_count++;
					end
					if (frame_last !== want.last) begin
						$error("frame_last: expected %0d, got %0d", want.last, frame_last);
						mismatch_count++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	initial begin
		int phase, r, c;
		pix_t p;
		foreach (line_mem[i, j])
			line_mem[i][j] = '0;
		foreach (win[i, j])
			win[i][j] = '0;
		sender_gap_pct = 18;
		receiver_stall_pct = 57;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Flat frame with a zero threshold: the only result sits exactly on the inner limit.
		configure(11'd0, 11'd2, 8'h5A, 32'h11223344, 32'hAABBCCDD, 10'd0, 24'd0);
		for (c = 0; c < 9; c++) begin
			p = '0;
			p.stencil = (c == 4) ? 8'hA5 : 8'h5A;
			send_pixel(p);
		end

		settle();
		configure(11'd5, 11'd4, 8'h00, 32'hFFFFFFFF, 32'h00000000, 10'd300, 24'hFFFFFF);
		for (r = 0; r < 4; r++)
			for (c = 0; c < 5; c++) begin
				p.depth = (c >= 3) ? '1 : '0;
				p.r = (r >= 2) ? 8'hFF : 8'h00;
				p.g = (c == 0) ? 8'hFF : 8'h00;
				p.b = ((r + c) % 2 != 0) ? 8'hFF : 8'h00;
				p.stencil = (c == 2 && r == 2) ? 8'h00 : 8'hFF;
				send_pixel(p);
			end

		// The twelve-pixel-wide frame writes every line-store column that later frames of at
		// most twelve columns use, so size changes part-way through those frames only read stored pixels.
		settle();
		chan_spread = 60;
		depth_spread = 16000;
		configure(11'd12, 11'd3, 8'h3C, $urandom, $urandom, 10'd120, 24'd25600);
		repeat (3 * 12) send_pixel(rand_pixel());

		settle();
		configure(11'd7, 11'd5, 8'($urandom), $urandom, $urandom, 10'd90, 24'd20000);
		repeat (17) send_pixel(rand_pixel());
		settle();
		configure(11'd3, 11'd3, 8'($urandom), $urandom, $urandom, 10'd90, 24'd20000);
		repeat (8) send_pixel(rand_pixel());

		for (phase = 0; phase < 12; phase++) begin
			settle();
			if (phase == 4) begin
				sender_gap_pct = 57;
				receiver_stall_pct = 18;
				configure(11'h7FF, 11'h7FF, 8'h00, $urandom, $urandom, 10'd100, 24'd15000);
				repeat (40) send_pixel(rand_pixel());
				settle();
			end
			if (phase == 8) begin
				sender_gap_pct = 0;
				receiver_stall_pct = 0;
			end
			case ($urandom_range(3))
				0: chan_spread = 0;
				1: chan_spread = 8;
				2: chan_spread = 64;
				default: chan_spread = 255;
			endcase
			case ($urandom_range(3))
				0: depth_spread = 0;
				1: depth_spread = 256;
				2: depth_spread = 40000;
				default: depth_spread = 24'hFFFFFF;
			endcase
			configure(
				($urandom_range(7) == 0) ? 11'($urandom_range(2)) : 11'($urandom_range(12, 3)),
				($urandom_range(7) == 0) ? 11'($urandom_range(2)) : 11'($urandom_range(8, 3)),
				8'($urandom), $urandom, $urandom,
				($urandom_range(4) == 0) ? 10'd1023 : 10'($urandom_range(3 * chan_spread)),
				($urandom_range(4) == 0) ? 24'hFFFFFF : 24'($urandom_range(depth_spread)));
			repeat (52) send_pixel(rand_pixel());
		end

		settle();
		if (mismatch_count == 0)
			$display("sobel_edge_outline: match");
		else
			$display("sobel_edge_outline: mismatch");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("sobel_edge_outline: mismatch");
		$finish;
	end

endmodule

// File: files.f
rtl/seo_pkg.sv
rtl/seo_line_store.sv
rtl/seo_window.sv
rtl/seo_classify.sv
rtl/sobel_edge_outline.sv
verif/tb_sobel_edge_outline.sv
